@@ rtl/core/llwd_pkg.sv @@
`timescale 1ns / 1ps

package llwd_pkg;

    // Fixed field widths
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned LOAD_W   = 16;
    localparam int unsigned QUEUE_W  = 16;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned SPAWN_W  = 5;
    localparam int unsigned CFG_IX_W = 2;
    localparam int unsigned CFG_D_W  = 16;
    localparam int unsigned LIMIT_W  = 5;
    localparam int unsigned MAX_SLOTS_ADDR = 16;   // slots reachable by a 4-bit slot field
    localparam int unsigned POOL_MAX = 16;
    // Grow accumulator holds up to (POOL_MAX + 1) * 65535
    localparam int unsigned ACC_W    = 21;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_UPDATE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GROW     = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_UPDATED = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_CHOSEN  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_SPAWN   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_BUSY    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_GROW    = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IX_W-1:0] CFG_CONC_LIMIT = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_POOL_CAP   = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_GROW_THR   = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_GROW
    } t_state;

endpackage

@@ rtl/core/least_loaded_worker_dispatcher_top.sv @@
`timescale 1ns / 1ps

// Least-loaded worker dispatcher. Raise start for one cycle while busy is low to
// hand in one beat; each beat yields exactly one result beat, shown on o_status,
// o_chosen_slot and o_spawn_count for a single cycle with o_valid high. The
// receiver cannot stall, so sample the result on the cycle o_valid is high.
// Per beat: a slot update, an unused kind and a dispatch on an empty pool
// answer straight from idle and keep busy low, so a new beat may follow at
// once. A dispatch scans the slot table one entry per cycle through a single
// read port of the load memory, over N = min(SLOTS, 16) entries, then drains
// the last entry read before it answers. A grow check runs one shared adder and
// comparator that steps a multiple of the threshold up towards the queue
// length, one step per cycle, until its count reaches min(queue / threshold,
// pool limit).
// Configuration writes land on the edge where i_cfg_we is high; write them only
// while the block is idle. Slot marks come out of reset cleared (empty pool); the
// load memory needs no clearing since a load is only read behind a set present
// mark.
module least_loaded_worker_dispatcher_top #(
    parameter int unsigned SLOTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [llwd_pkg::KIND_W-1:0]   i_kind,
    input  logic [llwd_pkg::SLOT_W-1:0]   i_slot,
    input  logic                          i_slot_present,
    input  logic                          i_slot_active,
    input  logic [llwd_pkg::LOAD_W-1:0]   i_slot_load,
    input  logic [llwd_pkg::QUEUE_W-1:0]  i_queue_length,
    input  logic                          i_cfg_we,
    input  logic [llwd_pkg::CFG_IX_W-1:0] i_cfg_index,
    input  logic [llwd_pkg::CFG_D_W-1:0]  i_cfg_data,
    output logic                          o_valid,
    output logic [llwd_pkg::STATUS_W-1:0] o_status,
    output logic [llwd_pkg::SLOT_W-1:0]   o_chosen_slot,
    output logic [llwd_pkg::SPAWN_W-1:0]  o_spawn_count
);
    import llwd_pkg::*;

    // Only slots addressable by the 4-bit slot field can ever hold a worker
    localparam int unsigned NSCAN = (SLOTS < MAX_SLOTS_ADDR) ? SLOTS : MAX_SLOTS_ADDR;
    localparam int unsigned IW    = (NSCAN > 1) ? $clog2(NSCAN) : 1;
    localparam int unsigned SW    = $clog2(NSCAN + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(NSCAN - 1);

    // Configuration registers
    logic [LOAD_W-1:0]  r_cfg_conc;
    logic [LIMIT_W-1:0] r_cfg_pool;
    logic [QUEUE_W-1:0] r_cfg_thr;

    // Control state
    t_state             r_state, n_state;
    logic [NSCAN-1:0]   r_present, n_present;
    logic [NSCAN-1:0]   r_active, n_active;
    logic [SW-1:0]      r_pool_size, n_pool_size;
    logic               r_rd_vld;
    logic               r_valid, n_valid;

    // Datapath state
    logic [IW-1:0]      r_idx, n_idx;
    logic [IW-1:0]      r_rd_idx;
    logic [LOAD_W-1:0]  r_rd_load;
    logic               r_found, n_found;
    logic [IW-1:0]      r_best_idx, n_best_idx;
    logic [LOAD_W-1:0]  r_best_load, n_best_load;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [SPAWN_W-1:0] r_k, n_k;
    logic               r_gt, n_gt;
    logic [QUEUE_W-1:0] r_queue, n_queue;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [SLOT_W-1:0]  r_chosen, n_chosen;
    logic [SPAWN_W-1:0] r_spawn, n_spawn;

    // Load memory, one write port for updates and one read port for the scan
    logic [LOAD_W-1:0]  r_load_mem [NSCAN];
    logic               w_mem_we;
    logic [IW-1:0]      w_wr_idx;

    // Scan compare
    logic               w_elig;
    logic               w_take;
    logic               w_cmp_found;
    logic [IW-1:0]      w_cmp_idx;
    logic [LOAD_W-1:0]  w_cmp_load;

    // Grow step
    logic [QUEUE_W-1:0] w_thr_eff;
    logic [LIMIT_W-1:0] w_lim_eff;
    logic [SPAWN_W-1:0] w_size;
    logic [ACC_W-1:0]   w_q_ext;
    logic [ACC_W-1:0]   w_acc_nxt;
    logic               w_fits;
    logic               w_gt_now;
    logic               w_gt_final;
    logic [SPAWN_W-1:0] w_target;
    logic [SPAWN_W-1:0] w_grow_spawn;

    logic               w_accept;
    logic               w_slot_ok;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_slot_ok = ({1'b0, i_slot} < (SLOT_W + 1)'(NSCAN));
    assign w_wr_idx = i_slot[IW-1:0];

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_chosen_slot = r_chosen;
    assign o_spawn_count = r_spawn;

    // Configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_conc <= LOAD_W'(1);
            r_cfg_pool <= LIMIT_W'(POOL_MAX);
            r_cfg_thr  <= QUEUE_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CONC_LIMIT: r_cfg_conc <= i_cfg_data[LOAD_W-1:0];
                CFG_POOL_CAP:   r_cfg_pool <= i_cfg_data[LIMIT_W-1:0];
                CFG_GROW_THR:   r_cfg_thr  <= i_cfg_data[QUEUE_W-1:0];
                default: ;      // drop writes to unused indexes
            endcase
        end
    end

    // Load memory: registered read at the scan pointer
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_load_mem[w_wr_idx] <= i_slot_load;
        end
        r_rd_load <= r_load_mem[r_idx];
        r_rd_idx  <= r_idx;
    end

    // Candidate compare on the entry read out last cycle
    always_comb begin
        w_elig = r_present[r_rd_idx] && r_active[r_rd_idx] && (r_rd_load < r_cfg_conc);
        w_take = r_rd_vld && w_elig && (!r_found || (r_rd_load < r_best_load));
        w_cmp_found = r_found || w_take;
        w_cmp_idx   = w_take ? r_rd_idx : r_best_idx;
        w_cmp_load  = w_take ? r_rd_load : r_best_load;
    end

    // Grow step: one add and compare per cycle towards min(q / thr, limit)
    always_comb begin
        w_thr_eff = (r_cfg_thr == '0) ? QUEUE_W'(1) : r_cfg_thr;
        if (r_cfg_pool == '0) begin
            w_lim_eff = LIMIT_W'(1);
        end else if (r_cfg_pool > LIMIT_W'(POOL_MAX)) begin
            w_lim_eff = LIMIT_W'(POOL_MAX);
        end else begin
            w_lim_eff = r_cfg_pool;
        end
        w_size     = SPAWN_W'(r_pool_size);
        w_q_ext    = ACC_W'(r_queue);
        w_acc_nxt  = r_acc + ACC_W'(w_thr_eff);
        w_fits     = (r_k < w_lim_eff) && (w_acc_nxt <= w_q_ext);
        // Capture whether queue exceeds size * thr when the count reaches size
        w_gt_now   = (r_acc < w_q_ext);
        w_gt_final = (r_k == w_size) ? w_gt_now : r_gt;
        w_target   = (r_k == '0) ? SPAWN_W'(1) : r_k;
        if ((w_size < w_lim_eff) && w_gt_final && (w_target > w_size)) begin
            w_grow_spawn = w_target - w_size;
        end else begin
            w_grow_spawn = '0;
        end
    end

    // Sequencer: next state and outputs
    always_comb begin
        n_state     = r_state;
        n_present   = r_present;
        n_active    = r_active;
        n_pool_size = r_pool_size;
        n_idx       = r_idx;
        n_found     = r_found;
        n_best_idx  = r_best_idx;
        n_best_load = r_best_load;
        n_acc       = r_acc;
        n_k         = r_k;
        n_gt        = r_gt;
        n_queue     = r_queue;
        n_valid     = 1'b0;
        n_status    = STAT_UPDATED;
        n_chosen    = '0;
        n_spawn     = '0;
        w_mem_we    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_kind)
                        KIND_UPDATE: begin
                            n_valid = 1'b1;
                            if (w_slot_ok) begin
                                w_mem_we = 1'b1;
                                n_present[w_wr_idx] = i_slot_present;
                                n_active[w_wr_idx]  = i_slot_active;
                                if (!r_present[w_wr_idx] && i_slot_present) begin
                                    n_pool_size = r_pool_size + SW'(1);
                                end else if (r_present[w_wr_idx] && !i_slot_present) begin
                                    n_pool_size = r_pool_size - SW'(1);
                                end
                            end
                        end
                        KIND_DISPATCH: begin
                            if (r_pool_size == '0) begin
                                n_valid  = 1'b1;
                                n_status = STAT_SPAWN;
                                n_spawn  = SPAWN_W'(1);
                            end else begin
                                n_idx   = '0;
                                n_found = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        KIND_GROW: begin
                            n_queue = i_queue_length;
                            n_acc   = '0;
                            n_k     = '0;
                            n_gt    = 1'b0;
                            n_state = S_GROW;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_found     = w_cmp_found;
                n_best_idx  = w_cmp_idx;
                n_best_load = w_cmp_load;
                n_idx       = r_idx + IW'(1);
                if (r_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_valid = 1'b1;
                if (w_cmp_found) begin
                    n_status = STAT_CHOSEN;
                    n_chosen = SLOT_W'(w_cmp_idx);
                end else begin
                    n_status = STAT_BUSY;
                end
                n_state = S_IDLE;
            end
            S_GROW: begin
                if (w_fits) begin
                    n_acc = w_acc_nxt;
                    n_k   = r_k + SPAWN_W'(1);
                    n_gt  = w_gt_final;
                end else begin
                    n_valid  = 1'b1;
                    n_status = STAT_GROW;
                    n_spawn  = w_grow_spawn;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_present   <= '0;
            r_active    <= '0;
            r_pool_size <= '0;
            r_rd_vld    <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_present   <= n_present;
            r_active    <= n_active;
            r_pool_size <= n_pool_size;
            r_rd_vld    <= (r_state == S_SCAN);
            r_valid     <= n_valid;
        end
    end

    // Datapath and result registers
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_found     <= n_found;
        r_best_idx  <= n_best_idx;
        r_best_load <= n_best_load;
        r_acc       <= n_acc;
        r_k         <= n_k;
        r_gt        <= n_gt;
        r_queue     <= n_queue;
        r_status    <= n_status;
        r_chosen    <= n_chosen;
        r_spawn     <= n_spawn;
    end

    // Results only come out once the sequencer is back at rest
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_IDLE))
        else $error("result beat while sequencer busy");

    // Every accepted beat either answers next cycle or holds the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_valid || busy))
        else $error("accepted beat neither answered nor in progress");

    // Pool size counter tracks the present marks
    a_pool_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pool_size == SW'($countones(r_present)))
        else $error("pool size counter out of step with present marks");

    // A chosen slot must be present and active
    a_chosen_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_status == STAT_CHOSEN)) |->
            (r_present[r_chosen[IW-1:0]] && r_active[r_chosen[IW-1:0]]))
        else $error("dispatch chose an ineligible slot");

endmodule

@@ sim/llwd_dispatch_checker.sv @@
`timescale 1ns / 1ps

// Watches the command, config and result ports of the dispatcher. Keeps its own
// copy of the slot table and config, queues one expected answer per accepted
// beat and compares each result beat with the oldest answer still due.
module llwd_dispatch_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic [llwd_pkg::KIND_W-1:0]    i_kind,
    input  logic [llwd_pkg::SLOT_W-1:0]    i_slot,
    input  logic                           i_slot_present,
    input  logic                           i_slot_active,
    input  logic [llwd_pkg::LOAD_W-1:0]    i_slot_load,
    input  logic [llwd_pkg::QUEUE_W-1:0]   i_queue_length,
    input  logic                           i_cfg_we,
    input  logic [llwd_pkg::CFG_IX_W-1:0]  i_cfg_index,
    input  logic [llwd_pkg::CFG_D_W-1:0]   i_cfg_data,
    input  logic                           i_valid,
    input  logic [llwd_pkg::STATUS_W-1:0]  i_status,
    input  logic [llwd_pkg::SLOT_W-1:0]    i_chosen_slot,
    input  logic [llwd_pkg::SPAWN_W-1:0]   i_spawn_count,
    output int                             o_fail_count,
    output int                             o_beats_due
);
    import llwd_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   chosen;
        logic [SPAWN_W-1:0]  spawn;
    } t_answer;

    t_answer answers_due[$];

    logic              present_mark [MAX_SLOTS_ADDR];
    logic              active_mark  [MAX_SLOTS_ADDR];
    logic [LOAD_W-1:0] load_count   [MAX_SLOTS_ADDR];
    logic [CFG_D_W-1:0] conc_limit;
    logic [LIMIT_W-1:0] pool_cap;
    logic [CFG_D_W-1:0] grow_thr;

    int n_fail = 0;

    assign o_fail_count = n_fail;

    task automatic flag(input string what, input int exp_v, input int got_v);
        if (n_fail < 10)
            $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v,
                     got_v);
        n_fail++;
    endtask

    always @(posedge i_clk) begin : watch
        t_answer     ans;
        t_answer     got;
        int unsigned pool_size;
        int unsigned thr_eff;
        int unsigned lim;
        int unsigned target;
        int unsigned spawn;
        int          best;

        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SLOTS_ADDR; i++) begin
                present_mark[i] = 1'b0;
                active_mark[i]  = 1'b0;
                load_count[i]   = '0;
            end
            conc_limit = 16'd1;
            pool_cap   = 5'd16;
            grow_thr   = 16'd1;
            answers_due.delete();
        end else begin
            // compare the result beat with the oldest answer due
            if (i_valid) begin
                if (answers_due.size() == 0) begin
                    flag("unexpected result status", -1, i_status);
                end else begin
                    ans = answers_due.pop_front();
                    got = '{i_status, i_chosen_slot, i_spawn_count};
                    if (got.status !== ans.status)
                        flag("status", ans.status, got.status);
                    if (got.chosen !== ans.chosen)
                        flag("chosen_slot", ans.chosen, got.chosen);
                    if (got.spawn !== ans.spawn)
                        flag("spawn_count", ans.spawn, got.spawn);
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CONC_LIMIT: conc_limit = i_cfg_data;
                    CFG_POOL_CAP:   pool_cap   = i_cfg_data[LIMIT_W-1:0];
                    CFG_GROW_THR:   grow_thr   = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_start && !i_busy) begin
                pool_size = 0;
                for (int i = 0; i < MAX_SLOTS_ADDR; i++)
                    pool_size += present_mark[i] ? 1 : 0;
                ans = '0;
                case (i_kind)
                    KIND_UPDATE: begin
                        ans.status = STAT_UPDATED;
                        present_mark[i_slot] = i_slot_present;
                        active_mark[i_slot]  = i_slot_active;
                        load_count[i_slot]   = i_slot_load;
                    end
                    KIND_DISPATCH: begin
                        if (pool_size == 0) begin
                            ans.status = STAT_SPAWN;
                            ans.spawn  = 5'd1;
                        end else begin
                            // lowest load below the limit, first slot wins a tie
                            best = -1;
                            for (int i = 0; i < MAX_SLOTS_ADDR; i++) begin
                                if (present_mark[i] && active_mark[i] &&
                                    load_count[i] < conc_limit &&
                                    (best < 0 || load_count[i] < load_count[best]))
                                    best = i;
                            end
                            if (best >= 0) begin
                                ans.status = STAT_CHOSEN;
                                ans.chosen = best[SLOT_W-1:0];
                            end else begin
                                ans.status = STAT_BUSY;
                            end
                        end
                    end
                    KIND_GROW: begin
                        thr_eff = (grow_thr == 0) ? 1 : grow_thr;
                        lim = pool_cap;
                        if (lim < 1)
                            lim = 1;
                        if (lim > POOL_MAX)
                            lim = POOL_MAX;
                        spawn = 0;
                        if (!(pool_size >= lim || pool_size * thr_eff >= i_queue_length)) begin
                            target = i_queue_length / thr_eff;
                            if (target > lim)
                                target = lim;
                            if (target < 1)
                                target = 1;
                            if (target > pool_size)
                                spawn = target - pool_size;
                        end
                        ans.status = STAT_GROW;
                        ans.spawn  = spawn[SPAWN_W-1:0];
                    end
                    default: ans.status = STAT_UPDATED;
                endcase
                answers_due.push_back(ans);
            end
        end
        o_beats_due <= answers_due.size();
    end

endmodule

@@ sim/tb_least_loaded_worker_dispatcher_top.sv @@
`timescale 1ns / 1ps

// Testbench top: resets the dispatcher, drives command and config beats and gives
// the verdict. All prediction and comparison lives in llwd_dispatch_checker.
module tb_least_loaded_worker_dispatcher_top;
    import llwd_pkg::*;

    // codes the package leaves unnamed
    localparam logic [KIND_W-1:0]   KIND_UNUSED = 2'd3;
    localparam logic [CFG_IX_W-1:0] CFG_UNUSED  = 2'd3;

    localparam int BEATS_PER_PHASE = 225;
    localparam int N_PHASES        = 8;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [KIND_W-1:0]    i_kind = '0;
    logic [SLOT_W-1:0]    i_slot = '0;
    logic                 i_slot_present = 1'b0;
    logic                 i_slot_active = 1'b0;
    logic [LOAD_W-1:0]    i_slot_load = '0;
    logic [QUEUE_W-1:0]   i_queue_length = '0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IX_W-1:0]  i_cfg_index = '0;
    logic [CFG_D_W-1:0]   i_cfg_data = '0;
    logic                 o_valid;
    logic [STATUS_W-1:0]  o_status;
    logic [SLOT_W-1:0]    o_chosen_slot;
    logic [SPAWN_W-1:0]   o_spawn_count;

    int fail_count;
    int beats_due;

    // sender idle chance in percent, and the live limits used to aim stimulus
    int           idle_pct = 0;
    logic [15:0]  cur_conc = 16'd1;
    logic [15:0]  cur_thr  = 16'd1;

    always #2 i_clk = ~i_clk;

    least_loaded_worker_dispatcher_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_slot         (i_slot),
        .i_slot_present (i_slot_present),
        .i_slot_active  (i_slot_active),
        .i_slot_load    (i_slot_load),
        .i_queue_length (i_queue_length),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_chosen_slot  (o_chosen_slot),
        .o_spawn_count  (o_spawn_count)
    );

    llwd_dispatch_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_kind         (i_kind),
        .i_slot         (i_slot),
        .i_slot_present (i_slot_present),
        .i_slot_active  (i_slot_active),
        .i_slot_load    (i_slot_load),
        .i_queue_length (i_queue_length),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (o_valid),
        .i_status       (o_status),
        .i_chosen_slot  (o_chosen_slot),
        .i_spawn_count  (o_spawn_count),
        .o_fail_count   (fail_count),
        .o_beats_due    (beats_due)
    );

    // Idle the sender cycle by cycle at the current idle chance, then present one
    // command beat and hold it until the edge that takes it (start high, busy
    // low). With no idling the next beat follows back to back.
    task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                             input logic pres, input logic act,
                             input logic [LOAD_W-1:0] load, input logic [QUEUE_W-1:0] qlen);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_kind         <= kind;
        i_slot         <= slot;
        i_slot_present <= pres;
        i_slot_active  <= act;
        i_slot_load    <= load;
        i_queue_length <= qlen;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // Write one register once the block has drained and gone idle.
    task automatic write_reg(input logic [CFG_IX_W-1:0] idx, input logic [CFG_D_W-1:0] data);
        if (start)
            start <= 1'b0;
        @(posedge i_clk);
        while (beats_due != 0 || busy)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_CONC_LIMIT)
            cur_conc = data;
        if (idx == CFG_GROW_THR)
            cur_thr = data;
    endtask

    // Loads: many small, some straddling the concurrency limit, rest anywhere.
    function automatic logic [LOAD_W-1:0] pick_load();
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 40)
            return LOAD_W'($urandom_range(15));
        if (r < 60) begin
            v = int'(cur_conc) + int'($urandom_range(3)) - 2;
            if (v < 0)
                v = 0;
            if (v > 65535)
                v = 65535;
            return LOAD_W'(v);
        end
        return LOAD_W'($urandom_range(65535));
    endfunction

    // Queue lengths: around multiples of the threshold, where the grow decision
    // flips, plus zero, small values and the full range.
    function automatic logic [QUEUE_W-1:0] pick_queue();
        int     r;
        longint v;
        longint thr_eff;
        r = $urandom_range(99);
        thr_eff = (cur_thr == 0) ? 1 : cur_thr;
        if (r < 25)
            return QUEUE_W'($urandom_range(40));
        if (r < 60) begin
            v = thr_eff * $urandom_range(17) + $urandom_range(2) - 1;
            if (v < 0)
                v = 0;
            if (v > 65535)
                v = 65535;
            return QUEUE_W'(v);
        end
        if (r < 70)
            return '0;
        return QUEUE_W'($urandom_range(65535));
    endfunction

    initial begin : stimulus
        int           sent;
        int           r;
        int           waited;
        logic [15:0]  conc_v;
        logic [15:0]  pool_v;
        logic [15:0]  thr_v;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset limits: concurrency 1, pool 16, threshold 1.
        send_beat(KIND_DISPATCH, 4'd0, 1'b0, 1'b0, 16'd0, 16'd0);     // empty pool: spawn one
        send_beat(KIND_GROW, 4'd0, 1'b0, 1'b0, 16'd0, 16'd0);         // empty queue: no growth
        send_beat(KIND_GROW, 4'd15, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);  // grow to pool limit
        send_beat(KIND_UNUSED, 4'hF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF); // unused kind answers zeros
        send_beat(KIND_UPDATE, 4'd15, 1'b1, 1'b0, 16'd0, 16'd0);      // present but inactive
        send_beat(KIND_DISPATCH, 4'd0, 1'b0, 1'b0, 16'd0, 16'd0);     // nobody eligible: busy
        send_beat(KIND_GROW, 4'd0, 1'b0, 1'b0, 16'd0, 16'hFFFF);
        send_beat(KIND_UPDATE, 4'd9, 1'b0, 1'b1, 16'd0, 16'd0);       // active but absent
        send_beat(KIND_UPDATE, 4'd7, 1'b1, 1'b1, 16'd0, 16'd0);
        send_beat(KIND_UPDATE, 4'd3, 1'b1, 1'b1, 16'd0, 16'd0);
        send_beat(KIND_DISPATCH, 4'd0, 1'b0, 1'b0, 16'd0, 16'd0);     // tie goes to lower slot

        write_reg(CFG_CONC_LIMIT, 16'hFFFF);
        send_beat(KIND_UPDATE, 4'd0, 1'b1, 1'b1, 16'hFFFF, 16'd0);    // at the limit: ineligible
        send_beat(KIND_UPDATE, 4'd12, 1'b1, 1'b1, 16'hFFFE, 16'd0);
        send_beat(KIND_UPDATE, 4'd3, 1'b1, 1'b1, 16'd5, 16'd0);
        send_beat(KIND_DISPATCH, 4'd0, 1'b0, 1'b0, 16'd0, 16'd0);
        send_beat(KIND_UPDATE, 4'd7, 1'b1, 1'b1, 16'hFFFF, 16'd0);
        send_beat(KIND_DISPATCH, 4'd0, 1'b0, 1'b0, 16'd0, 16'd0);

        write_reg(CFG_CONC_LIMIT, 16'd0);                             // zero limit: all busy
        send_beat(KIND_DISPATCH, 4'd0, 1'b0, 1'b0, 16'd0, 16'd0);

        write_reg(CFG_GROW_THR, 16'd0);                               // zero threshold acts as 1
        write_reg(CFG_POOL_CAP, 16'd0);                               // zero pool limit acts as 1
        send_beat(KIND_GROW, 4'd0, 1'b0, 1'b0, 16'd0, 16'd100);
        write_reg(CFG_POOL_CAP, 16'd31);                              // above 16 acts as 16
        send_beat(KIND_GROW, 4'd0, 1'b0, 1'b0, 16'd0, 16'd100);
        write_reg(CFG_POOL_CAP, 16'hFFE4);                            // upper data bits dropped
        write_reg(CFG_GROW_THR, 16'hFFFF);
        send_beat(KIND_GROW, 4'd0, 1'b0, 1'b0, 16'd0, 16'hFFFF);
        write_reg(CFG_UNUSED, 16'hFFFF);                              // ignored index
        send_beat(KIND_GROW, 4'd0, 1'b0, 1'b0, 16'd0, 16'd40000);
        send_beat(KIND_DISPATCH, 4'd0, 1'b0, 1'b0, 16'd0, 16'd0);

        // Random phases: new limits each phase, sender idling 35% then 58% then none.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph == 0) begin
                conc_v = 16'hFFFF;
                pool_v = 16'd16;
                thr_v  = 16'hFFFF;
            end else if (ph == 1) begin
                conc_v = 16'd1;
                pool_v = 16'd1;
                thr_v  = 16'd1;
            end else begin
                case ($urandom_range(5))
                    0: conc_v = 16'd0;
                    1: conc_v = 16'd1;
                    2: conc_v = 16'd2;
                    3: conc_v = 16'($urandom_range(3, 40));
                    4: conc_v = 16'hFFFF;
                    default: conc_v = 16'($urandom_range(65535));
                endcase
                case ($urandom_range(4))
                    0: pool_v = 16'd0;
                    1: pool_v = 16'($urandom_range(1, 16));
                    2: pool_v = 16'($urandom_range(17, 31));
                    3: pool_v = 16'd16;
                    default: pool_v = 16'($urandom_range(65535));
                endcase
                case ($urandom_range(4))
                    0: thr_v = 16'd0;
                    1: thr_v = 16'd1;
                    2: thr_v = 16'($urandom_range(2, 64));
                    3: thr_v = 16'hFFFF;
                    default: thr_v = 16'($urandom_range(65535));
                endcase
            end
            write_reg(CFG_CONC_LIMIT, conc_v);
            write_reg(CFG_POOL_CAP, pool_v);
            write_reg(CFG_GROW_THR, thr_v);
            write_reg(CFG_UNUSED, 16'($urandom_range(65535)));

            idle_pct = (ph < 3) ? 35 : (ph < 6) ? 58 : 0;

            sent = 0;
            while (sent < BEATS_PER_PHASE) begin
                r = $urandom_range(99);
                if (r < 3) begin
                    // empty the whole pool, so dispatches hit the spawn path
                    for (int s = 0; s < MAX_SLOTS_ADDR; s++)
                        send_beat(KIND_UPDATE, SLOT_W'(s), 1'b0, 1'($urandom_range(1)),
                                  pick_load(), 16'($urandom_range(65535)));
                    sent += MAX_SLOTS_ADDR;
                end else begin
                    if (r < 5)
                        send_beat(KIND_UNUSED, 4'($urandom_range(15)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)), 16'($urandom_range(65535)),
                                  16'($urandom_range(65535)));
                    else if (r < 50)
                        send_beat(KIND_UPDATE, 4'($urandom_range(15)),
                                  1'($urandom_range(99) < 75), 1'($urandom_range(99) < 75),
                                  pick_load(), 16'($urandom_range(65535)));
                    else if (r < 85)
                        send_beat(KIND_DISPATCH, 4'($urandom_range(15)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)), 16'($urandom_range(65535)),
                                  16'($urandom_range(65535)));
                    else
                        send_beat(KIND_GROW, 4'($urandom_range(15)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)), 16'($urandom_range(65535)),
                                  pick_queue());
                    sent++;
                end
            end
        end

        // Drain: wait for the last answers, then let the block settle.
        if (start)
            start <= 1'b0;
        @(posedge i_clk);
        waited = 0;
        while (beats_due != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (24) @(posedge i_clk);

        if (fail_count == 0 && beats_due == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
